### design/cmmef_pkg.sv
// Shared constants and types of the cross-mean erosion filter.
package cmmef_pkg;

   localparam int MAX_WIDTH       = 1024;
   localparam int MAX_HEIGHT      = 4096;
   localparam int LEVEL_BITS      = 16;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int WIDTH_RESET     = 64;
   localparam int HEIGHT_RESET    = 64;
   localparam int TDATA_BITS      = ((LEVEL_BITS + 7) / 8) * 8;

   // Five-term sum and its division by five as a reciprocal multiply.
   localparam int SUM_BITS      = LEVEL_BITS + 3;
   localparam int DIV_SHIFT     = SUM_BITS + 3;
   localparam int DIV_MULT_BITS = SUM_BITS + 1;
   localparam int PROD_BITS     = SUM_BITS + DIV_MULT_BITS;
   localparam logic [DIV_MULT_BITS-1:0] DIV_MULT =
      DIV_MULT_BITS'(((2 ** DIV_SHIFT) + 4) / 5);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = HEIGHT_REG_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   // Result queue.
   localparam int FIFO_PTR_BITS = 3;
   localparam int FIFO_DEPTH    = 2 ** FIFO_PTR_BITS;
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

   // One line store entry: the row two back and the row one back at a column.
   typedef struct packed {
      logic [LEVEL_BITS-1:0] older;
      logic [LEVEL_BITS-1:0] prev;
   } line_entry_type;

   localparam int ENTRY_BITS = 2 * LEVEL_BITS;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] pixel;
      logic                  last;
   } result_type;

   typedef struct packed {
      logic       a_valid;
      logic       b_valid;
      result_type a;
      result_type b;
   } fifo_push_type;

endpackage

### design/cmmef_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cmmef_ram #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 1024
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cmmef_result_fifo.sv
// Small result queue that takes up to two items per cycle and gives one.
module cmmef_result_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  cmmef_pkg::fifo_push_type            push,
   input  logic                                pop,
   output logic                                out_valid,
   output cmmef_pkg::result_type               out_item,
   output logic [cmmef_pkg::FIFO_CNT_BITS-1:0] count
);
   import cmmef_pkg::*;

   result_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   head_ff, head_in;
   logic [FIFO_PTR_BITS-1:0]   tail_ff, tail_in;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0]   tail_next;
   logic [FIFO_CNT_BITS-1:0]   push_n;
   logic                       do_pop;

   assign tail_next = tail_ff + FIFO_PTR_BITS'(1);
   assign push_n    = FIFO_CNT_BITS'(push.a_valid) + FIFO_CNT_BITS'(push.b_valid);
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      head_in  = do_pop ? head_ff + FIFO_PTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + FIFO_PTR_BITS'(push_n);
      count_in = count_ff + push_n - FIFO_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // The second item of a pair always lands right behind the first.
   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         if (push.a_valid && (FIFO_PTR_BITS'(i) == tail_ff)) begin
            entry_ff[i] <= push.a;
         end else if (push.b_valid && (FIFO_PTR_BITS'(i) == tail_next)) begin
            entry_ff[i] <= push.b;
         end
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[head_ff];
   assign count     = count_ff;

endmodule

### design/cross_mean_min_erosion_filter.sv
// Top level of the cross-mean erosion filter over a raster-order pixel stream.
//
//   channel  ports                          carries
//   -------  -----------------------------  --------------------------------
//   input    req_tvalid/tready/tdata        pixel_in, one item per pixel
//   output   rsp_tvalid/tready/tdata/tlast  pixel_out, tlast = frame_end
//   config   csr_valid/ready/index/data     frame_width (0), frame_height (1)
//
// One input item per clock is taken while the result queue has room; the
// line store RAM is read one column ahead and written once per item. The
// last row gives two results per item, and the one-per-clock output then
// holds the input back. Reset clears counters and queue and loads the default
// geometry; the line store is not cleared. csr_ready is always high.
module cross_mean_min_erosion_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cmmef_pkg::TDATA_BITS-1:0]     req_tdata,   // [15:0] pixel_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cmmef_pkg::TDATA_BITS-1:0]     rsp_tdata,   // [15:0] pixel_out
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cmmef_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cmmef_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import cmmef_pkg::*;

   // Geometry, held as last column and last row.
   logic [COL_BITS-1:0]        wlast_ff, wlast_in;
   logic [ROW_BITS-1:0]        hlast_ff, hlast_in;
   logic [COL_BITS-1:0]        col_ff, col_in;
   logic [ROW_BITS-1:0]        row_ff, row_in;

   line_entry_type             cur_ff, cur_in;
   line_entry_type             first_ff;
   logic [LEVEL_BITS-1:0]      left_ff;

   line_entry_type             ram_rdata;
   line_entry_type             new_entry;
   logic [COL_BITS-1:0]        rd_addr;

   logic                       csr_write;
   logic                       accept;
   logic                       last_col;
   logic                       last_row;
   logic [LEVEL_BITS-1:0]      px;
   logic [SUM_BITS-1:0]        sum;
   logic [WIDTH_REG_BITS-1:0]  width_val;
   logic [HEIGHT_REG_BITS-1:0] height_val;

   // Stage between the RAM side and the result queue.
   logic                       s1_valid_ff;
   logic                       s1_two_ff;
   logic                       s1_interior_ff;
   logic                       s1_last_ff;
   logic [SUM_BITS-1:0]        s1_sum_ff;
   logic [LEVEL_BITS-1:0]      s1_center_ff;
   logic [LEVEL_BITS-1:0]      s1_px_ff;

   logic [PROD_BITS-1:0]       product;
   logic [LEVEL_BITS-1:0]      mean;
   logic [LEVEL_BITS-1:0]      eroded;
   fifo_push_type              push;
   result_type                 head;
   logic [FIFO_CNT_BITS-1:0]   fifo_count;
   logic [FIFO_CNT_BITS+1:0]   fill_worst;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign px        = req_tdata[LEVEL_BITS-1:0];
   assign accept    = req_tvalid && req_tready;
   assign last_col  = (col_ff == wlast_ff);
   assign last_row  = (row_ff == hlast_ff);

   // Room for the stage's pending results plus a full pair from a new item.
   assign fill_worst = (FIFO_CNT_BITS+2)'(fifo_count)
                     + (FIFO_CNT_BITS+2)'(s1_valid_ff)
                     + (FIFO_CNT_BITS+2)'(s1_valid_ff && s1_two_ff)
                     + (FIFO_CNT_BITS+2)'(2);
   assign req_tready = (fill_worst <= (FIFO_CNT_BITS+2)'(FIFO_DEPTH));

   assign width_val  = csr_data[WIDTH_REG_BITS-1:0];
   assign height_val = csr_data[HEIGHT_REG_BITS-1:0];

   always_comb begin
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
         case (csr_index)
            REG_FRAME_WIDTH: begin
               if (width_val < WIDTH_REG_BITS'(3)) begin
                  wlast_in = COL_BITS'(2);
               end else if (width_val > WIDTH_REG_BITS'(MAX_WIDTH)) begin
                  wlast_in = COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  wlast_in = COL_BITS'(width_val - WIDTH_REG_BITS'(1));
               end
            end
            REG_FRAME_HEIGHT: begin
               if (height_val < HEIGHT_REG_BITS'(3)) begin
                  hlast_in = ROW_BITS'(2);
               end else if (height_val > HEIGHT_REG_BITS'(MAX_HEIGHT)) begin
                  hlast_in = ROW_BITS'(MAX_HEIGHT - 1);
               end else begin
                  hlast_in = ROW_BITS'(height_val - HEIGHT_REG_BITS'(1));
               end
            end
            default: begin
               // Writes to unknown registers leave the geometry alone.
               col_in = col_ff;
               row_in = row_ff;
            end
         endcase
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // The RAM always reads the column after the next one to be processed, so
   // its output is the right neighbor of the waiting item. That column is not
   // the one written in the same cycle, unless a geometry write meets an accepted item.
   assign rd_addr = col_in + COL_BITS'(1);

   assign new_entry.older = cur_ff.prev;
   assign new_entry.prev  = px;

   // The entry of column 0 is not read back at a row wrap; it is kept aside.
   always_comb begin
      cur_in = ram_rdata;
      if (last_col) begin
         cur_in = first_ff;
      end
   end

   assign sum = SUM_BITS'(cur_ff.prev) + SUM_BITS'(cur_ff.older) + SUM_BITS'(left_ff)
              + SUM_BITS'(ram_rdata.prev) + SUM_BITS'(px);

   cmmef_ram #(
      .DATA_WIDTH (ENTRY_BITS),
      .DEPTH      (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (new_entry),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= COL_BITS'(WIDTH_RESET - 1);
         hlast_ff    <= ROW_BITS'(HEIGHT_RESET - 1);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wlast_ff    <= wlast_in;
         hlast_ff    <= hlast_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept && (row_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff         <= cur_in;
         left_ff        <= cur_ff.prev;
         s1_two_ff      <= last_row;
         s1_interior_ff <= (row_ff != ROW_BITS'(1)) && (col_ff != '0) && !last_col;
         s1_last_ff     <= last_col;
         s1_sum_ff      <= sum;
         s1_center_ff   <= cur_ff.prev;
         s1_px_ff       <= px;
         if (col_ff == '0) begin
            first_ff <= new_entry;
         end
      end
   end

   // Truncating division by five through a reciprocal multiply.
   assign product = PROD_BITS'(s1_sum_ff) * PROD_BITS'(DIV_MULT);
   assign mean    = LEVEL_BITS'(product >> DIV_SHIFT);
   assign eroded  = (s1_interior_ff && (mean < s1_center_ff)) ? mean : s1_center_ff;

   always_comb begin
      push.a_valid = s1_valid_ff;
      push.b_valid = s1_valid_ff && s1_two_ff;
      push.a.pixel = eroded;
      push.a.last  = 1'b0;
      push.b.pixel = s1_px_ff;
      push.b.last  = s1_last_ff;
   end

   cmmef_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (head),
      .count     (fifo_count)
   );

   assign rsp_tdata = TDATA_BITS'(head.pixel);
   assign rsp_tlast = head.last;

endmodule
